// ===== hdl/sha256_pkg.sv =====
// Shared types, constants and round functions for the SHA-256 engine.
package sha256_pkg;

    localparam int unsigned WordW  = 32;
    localparam int unsigned NumH   = 8;
    localparam int unsigned NumBlk = 16;
    localparam int unsigned NumRnd = 64;

    localparam logic [31:0] HASH_INIT [NumH] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_K [NumRnd] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [7:0]  PAD_BYTE = 8'h80;
    localparam logic [2:0]  MAX_BYTES = 3'd4;
    localparam logic [5:0]  LEN_POS   = 6'd56;
    localparam logic [2:0]  LAST_IDX  = 3'd7;

    // Controller states, one-hot.
    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_PACK   = 7'b0000010,
        ST_PAD1   = 7'b0000100,
        ST_PAD2   = 7'b0001000,
        ST_ROUND  = 7'b0010000,
        ST_UPDATE = 7'b0100000,
        ST_OUT    = 7'b1000000
    } t_state;

    // Commands from controller to datapath.
    typedef struct packed {
        logic accept;   // latch input item
        logic pack;     // pack pending bytes into the block buffer
        logic pad1;     // 0x80, zeros, and length if it fits
        logic pad2;     // extra block of zeros and length
        logic round;    // one compression round
        logic update;   // fold working vars into chain hash
        logic emit;     // digest word taken
        logic done;     // final digest word taken, restart message
    } t_cmd;

    // Status from datapath to controller.
    typedef struct packed {
        logic pack_full;   // this pack completes the block
        logic pend_empty;  // no bytes of the current item left
        logic last;        // current item closes the message
        logic pad_second;  // length does not fit after the 0x80 byte
        logic round_last;  // round 63 in progress
        logic out_last;    // digest word 7 is on the port
    } t_sts;

    function automatic logic [31:0] f_rotr(input logic [31:0] x, input int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] f_bsig0(input logic [31:0] x);
        return f_rotr(x, 2) ^ f_rotr(x, 13) ^ f_rotr(x, 22);
    endfunction

    function automatic logic [31:0] f_bsig1(input logic [31:0] x);
        return f_rotr(x, 6) ^ f_rotr(x, 11) ^ f_rotr(x, 25);
    endfunction

    function automatic logic [31:0] f_ssig0(input logic [31:0] x);
        return f_rotr(x, 7) ^ f_rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] f_ssig1(input logic [31:0] x);
        return f_rotr(x, 17) ^ f_rotr(x, 19) ^ (x >> 10);
    endfunction

endpackage

// ===== hdl/sha256_ctrl.sv =====
// Sequencer for the SHA-256 engine: packing, padding, rounds and digest output.
module sha256_ctrl import sha256_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_out_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd,
    output logic o_in_ready,
    output logic o_out_valid
);

    t_state r_state, n_state;
    logic   r_padding, n_padding;
    logic   r_need2, n_need2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_padding <= 1'b0;
            r_need2   <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_padding <= n_padding;
            r_need2   <= n_need2;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_padding = r_padding;
        n_need2   = r_need2;
        o_cmd     = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = ST_PACK;
                end
            end
            ST_PACK: begin
                o_cmd.pack = 1'b1;
                if (i_sts.pack_full) begin
                    n_state = ST_ROUND;
                end else if (i_sts.last) begin
                    n_state = ST_PAD1;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_PAD1: begin
                o_cmd.pad1 = 1'b1;
                n_padding  = 1'b1;
                n_need2    = i_sts.pad_second;
                n_state    = ST_ROUND;
            end
            ST_PAD2: begin
                o_cmd.pad2 = 1'b1;
                n_need2    = 1'b0;
                n_state    = ST_ROUND;
            end
            ST_ROUND: begin
                o_cmd.round = 1'b1;
                if (i_sts.round_last) begin
                    n_state = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                o_cmd.update = 1'b1;
                if (r_padding) begin
                    n_state = r_need2 ? ST_PAD2 : ST_OUT;
                end else if (!i_sts.pend_empty) begin
                    n_state = ST_PACK;
                end else if (i_sts.last) begin
                    n_state = ST_PAD1;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_OUT: begin
                if (i_out_ready) begin
                    o_cmd.emit = 1'b1;
                    if (i_sts.out_last) begin
                        o_cmd.done = 1'b1;
                        n_padding  = 1'b0;
                        n_state    = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = (r_state == ST_OUT);

endmodule

// ===== hdl/sha256_dp.sv =====
// SHA-256 datapath: byte packer, block buffer as message schedule, round unit, chain hash.
module sha256_dp import sha256_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    input  logic [31:0] i_data_word,
    input  logic [2:0]  i_byte_count,
    input  logic        i_last_item,
    output t_sts        o_sts,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_index
);

    logic [31:0] r_blk [NumBlk];
    logic [31:0] n_blk [NumBlk];
    logic [31:0] r_hash [NumH];
    logic [31:0] r_v [NumH];
    logic [31:0] r_pend;
    logic [2:0]  r_rem;
    logic        r_last;
    logic [63:0] r_len;
    logic [5:0]  r_fill;
    logic [5:0]  r_rnd;
    logic [2:0]  r_oidx;

    logic [6:0]  room;
    logic [2:0]  pack_n;
    logic        pack_full;
    logic        blk_start;
    logic [31:0] sched_new;
    logic [31:0] t1;
    logic [31:0] t2;
    logic [31:0] ch;
    logic [31:0] maj;

    // Bytes this cycle: whatever is pending, cut at the block end.
    assign room      = 7'd64 - {1'b0, r_fill};
    assign pack_n    = ({4'b0, r_rem} <= room) ? r_rem : room[2:0];
    assign pack_full = ({1'b0, r_fill} + {4'b0, pack_n}) == 7'd64;
    assign blk_start = (i_cmd.pack && pack_full) || i_cmd.pad1 || i_cmd.pad2;

    assign o_sts.pack_full  = pack_full;
    assign o_sts.pend_empty = (r_rem == 3'd0);
    assign o_sts.last       = r_last;
    assign o_sts.pad_second = (r_fill >= LEN_POS);
    assign o_sts.round_last = (r_rnd == 6'd63);
    assign o_sts.out_last   = (r_oidx == LAST_IDX);

    assign o_digest_word = r_hash[r_oidx];
    assign o_word_index  = r_oidx;

    // Block buffer next value: byte lane writes for packing and padding,
    // one-word shift with schedule expansion during rounds.
    always_comb begin
        logic [6:0] pos;
        logic [6:0] off;
        logic [1:0] lane;
        n_blk = r_blk;
        for (int p = 0; p < 64; p++) begin
            pos  = 7'(p);
            off  = pos - {1'b0, r_fill};
            lane = 2'd3 - off[1:0];
            if (i_cmd.pack) begin
                if (pos >= {1'b0, r_fill} && off < {4'b0, pack_n}) begin
                    n_blk[p / 4][8 * (3 - (p % 4)) +: 8] = r_pend[{lane, 3'b000} +: 8];
                end
            end else if (i_cmd.pad1) begin
                if (pos == {1'b0, r_fill}) begin
                    n_blk[p / 4][8 * (3 - (p % 4)) +: 8] = PAD_BYTE;
                end else if (pos > {1'b0, r_fill}) begin
                    if (p >= 56 && r_fill < LEN_POS) begin
                        n_blk[p / 4][8 * (3 - (p % 4)) +: 8] = r_len[8 * (63 - p) +: 8];
                    end else begin
                        n_blk[p / 4][8 * (3 - (p % 4)) +: 8] = 8'h00;
                    end
                end
            end else if (i_cmd.pad2) begin
                if (p >= 56) begin
                    n_blk[p / 4][8 * (3 - (p % 4)) +: 8] = r_len[8 * (63 - p) +: 8];
                end else begin
                    n_blk[p / 4][8 * (3 - (p % 4)) +: 8] = 8'h00;
                end
            end
        end
        if (i_cmd.round) begin
            for (int i = 0; i < NumBlk - 1; i++) begin
                n_blk[i] = r_blk[i + 1];
            end
            n_blk[NumBlk - 1] = sched_new;
        end
    end

    assign sched_new = f_ssig1(r_blk[14]) + r_blk[9] + f_ssig0(r_blk[1]) + r_blk[0];

    assign ch  = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
    assign maj = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
    assign t1  = r_v[7] + f_bsig1(r_v[4]) + ch + ROUND_K[r_rnd] + r_blk[0];
    assign t2  = f_bsig0(r_v[0]) + maj;

    // Block buffer and working variables: payload, no reset.
    always_ff @(posedge i_clk) begin
        r_blk <= n_blk;
        if (i_cmd.accept) begin
            r_pend <= i_data_word;
        end else if (i_cmd.pack) begin
            r_pend <= r_pend << {pack_n, 3'b000};
        end
        if (i_cmd.accept) begin
            r_last <= i_last_item;
        end
        if (blk_start) begin
            r_v <= r_hash;
        end else if (i_cmd.round) begin
            r_v[7] <= r_v[6];
            r_v[6] <= r_v[5];
            r_v[5] <= r_v[4];
            r_v[4] <= r_v[3] + t1;
            r_v[3] <= r_v[2];
            r_v[2] <= r_v[1];
            r_v[1] <= r_v[0];
            r_v[0] <= t1 + t2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash <= HASH_INIT;
            r_rem  <= 3'd0;
            r_len  <= 64'd0;
            r_fill <= 6'd0;
            r_rnd  <= 6'd0;
            r_oidx <= 3'd0;
        end else begin
            if (i_cmd.accept) begin
                r_rem <= (i_byte_count > MAX_BYTES) ? MAX_BYTES : i_byte_count;
            end else if (i_cmd.pack) begin
                r_rem <= r_rem - pack_n;
            end
            if (i_cmd.done) begin
                r_len <= 64'd0;
            end else if (i_cmd.pack) begin
                r_len <= r_len + {58'd0, pack_n, 3'b000};
            end
            if (i_cmd.pack) begin
                r_fill <= r_fill + 6'(pack_n);
            end else if (i_cmd.pad1 || i_cmd.pad2 || i_cmd.done) begin
                r_fill <= 6'd0;
            end
            if (blk_start) begin
                r_rnd <= 6'd0;
            end else if (i_cmd.round) begin
                r_rnd <= r_rnd + 6'd1;
            end
            if (i_cmd.done) begin
                r_hash <= HASH_INIT;
            end else if (i_cmd.update) begin
                for (int i = 0; i < NumH; i++) begin
                    r_hash[i] <= r_hash[i] + r_v[i];
                end
            end
            if (i_cmd.done) begin
                r_oidx <= 3'd0;
            end else if (i_cmd.emit) begin
                r_oidx <= r_oidx + 3'd1;
            end
        end
    end

endmodule

// ===== hdl/sha256_hash_engine.sv =====
// SHA-256 engine top level: controller, datapath and interface checks.
// Sequence: an item is taken in IDLE and packed in the cycle after; each filled
//   64-byte block then runs 64 rounds, one per cycle, plus the hash fold.
// Items are taken only in IDLE; the single shared round unit hashes every block.
// Final item: one or two padding blocks, then eight digest items.
// Reset: synchronous active low; hash, length and fill restart, block buffer kept.
module sha256_hash_engine import sha256_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input item channel
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [31:0] i_data_word,
    input  logic [2:0]  i_byte_count,
    input  logic        i_last_item,
    // digest item channel
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_last_word
);

    t_cmd cmd;
    t_sts sts;

    // Controller walks IDLE -> PACK -> (ROUND -> UPDATE)* -> PAD1 [-> PAD2] -> OUT.
    sha256_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_cmd       (cmd),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid)
    );

    // Datapath holds all message state; digest words are read straight
    // from the chain hash, which holds still while the output is offered.
    sha256_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_data_word   (i_data_word),
        .i_byte_count  (i_byte_count),
        .i_last_item   (i_last_item),
        .o_sts         (sts),
        .o_digest_word (o_digest_word),
        .o_word_index  (o_word_index)
    );

    assign o_last_word = sts.out_last;

    // Never take input while a digest is being delivered.
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !o_in_ready)
        else $error("input ready while digest pending");

    // Digest words come out in order.
    a_index_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && !o_last_word) |=>
            (o_out_valid && o_word_index == 3'($past(o_word_index) + 3'd1)))
        else $error("digest word index out of sequence");

    // After the last digest word the engine is ready for a new message.
    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && o_last_word) |=> (o_in_ready && o_word_index == 3'd0))
        else $error("engine not idle after final digest word");

endmodule
